>>> rtl/ffr_pkg.sv
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants for the fixed-length frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ffr_pkg;

  localparam int unsigned HEADER_LEN = 3;
  localparam logic [7:0]  RESET_MARK = 8'hDD;

  // register reset values
  localparam logic [7:0] START_BYTE_RST = 8'hAC;
  localparam logic [7:0] SOURCE_ID_RST  = 8'h02;
  localparam logic [7:0] DEST_ID_RST    = 8'h00;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_START_BYTE = 2'd0;
  localparam logic [1:0] CFG_SOURCE_ID  = 2'd1;
  localparam logic [1:0] CFG_DEST_ID    = 2'd2;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_DONE    = 3'd2,
    ST_HDR_BAD = 3'd3,
    ST_SUM_BAD = 3'd4
  } status_t;

  typedef struct packed {
    logic    shift;
    status_t status;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/ffr_cell.sv
// ----------------------------------------------------------------------------
// ffr_cell
// One byte cell of the payload chain; loads its neighbour's byte on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ffr_cell (
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] d_in,
  output logic      [7:0] q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign byte_nxt = shift ? d_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q = byte_r;

endmodule

`default_nettype wire

>>> rtl/ffr_ctrl.sv
// ----------------------------------------------------------------------------
// ffr_ctrl
// Frame position counter, running sum, header match and configuration
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ffr_ctrl #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output ffr_pkg::ctl_t    ctl
);

  localparam logic [3:0] CHECK_POS = 4'(ffr_pkg::HEADER_LEN + PAYLOAD_BYTES);

  logic [7:0] start_byte_r, start_byte_nxt;
  logic [7:0] source_id_r, source_id_nxt;
  logic [7:0] dest_id_r, dest_id_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sum_add;
  logic [7:0] want;

  always_comb begin
    start_byte_nxt = start_byte_r;
    source_id_nxt  = source_id_r;
    dest_id_nxt    = dest_id_r;
    if (cfg_we) begin
      case (cfg_index)
        ffr_pkg::CFG_START_BYTE: start_byte_nxt = cfg_data;
        ffr_pkg::CFG_SOURCE_ID:  source_id_nxt  = cfg_data;
        ffr_pkg::CFG_DEST_ID:    dest_id_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  assign sum_add = sum_r + rx_byte;
  assign want    = (pos_r == 4'd1) ? source_id_r : dest_id_r;

  always_comb begin
    ctl.shift  = 1'b0;
    ctl.status = ffr_pkg::ST_HUNT;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    if (pos_r == 4'd0) begin
      if (rx_byte == start_byte_r) begin
        pos_nxt    = pos_r + 4'd1;
        sum_nxt    = sum_add;
        ctl.status = ffr_pkg::ST_ACCEPT;
      end
    end else if (pos_r == 4'd1 || pos_r == 4'd2) begin
      if (rx_byte == want) begin
        pos_nxt    = pos_r + 4'd1;
        sum_nxt    = sum_add;
        ctl.status = ffr_pkg::ST_ACCEPT;
      end else begin
        pos_nxt    = 4'd0;
        sum_nxt    = 8'd0;
        ctl.status = ffr_pkg::ST_HDR_BAD;
      end
    end else if (pos_r < CHECK_POS) begin
      ctl.shift  = 1'b1;
      pos_nxt    = pos_r + 4'd1;
      sum_nxt    = sum_add;
      ctl.status = ffr_pkg::ST_ACCEPT;
    end else if (pos_r == CHECK_POS) begin
      ctl.status = (sum_r == rx_byte) ? ffr_pkg::ST_DONE : ffr_pkg::ST_SUM_BAD;
      pos_nxt    = 4'd0;
      sum_nxt    = 8'd0;
    end else begin
      // unreachable position: drop back to hunting
      pos_nxt = 4'd0;
      sum_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= ffr_pkg::START_BYTE_RST;
      source_id_r  <= ffr_pkg::SOURCE_ID_RST;
      dest_id_r    <= ffr_pkg::DEST_ID_RST;
      pos_r        <= 4'd0;
      sum_r        <= 8'd0;
    end else begin
      start_byte_r <= start_byte_nxt;
      source_id_r  <= source_id_nxt;
      dest_id_r    <= dest_id_nxt;
      if (accept) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/fixed_frame_receiver_sum_check.sv
// ----------------------------------------------------------------------------
// fixed_frame_receiver_sum_check
// Hunts received bytes for a fixed-length frame with an 8-bit sum checksum
// and reports one status per byte, with the payload on a good frame.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid/in_ready     in_rx_byte[7:0]
//   out_     output     out_valid/out_ready   out_status, out_payload,
//                                             out_reset_request
//   cfg_     input      cfg_valid/cfg_ready   cfg_index[1:0], cfg_data[7:0]
//
// One byte is taken per cycle unless the output stalls; its result appears
// in the output register on the next cycle. Payload bytes move along a chain
// of byte cells, one step per payload transfer. The input stalls only while
// a held result is not taken. Synchronous reset returns to hunting and
// reloads the registers; the configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_frame_receiver_sum_check #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  out_status,
  output logic      [63:0] out_payload,
  output logic             out_reset_request,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  ffr_pkg::ctl_t ctl;
  logic          accept;
  logic [7:0]    cell_q [PAYLOAD_BYTES];
  logic [63:0]   payload_all;
  logic          rreq_all;
  logic          done;

  logic                out_valid_r, out_valid_nxt;
  ffr_pkg::status_t    status_r;
  logic [63:0]         payload_r;
  logic                rreq_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  ffr_ctrl #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl)
  );

  // newest byte enters at the top; after a full payload cell i holds byte i
  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_chain
    logic [7:0] d_in;
    if (i == PAYLOAD_BYTES - 1) begin : g_top
      assign d_in = in_rx_byte;
    end else begin : g_mid
      assign d_in = cell_q[i+1];
    end
    ffr_cell u_cell (
      .clk   (clk),
      .shift (accept && ctl.shift),
      .d_in  (d_in),
      .q     (cell_q[i])
    );
  end

  always_comb begin
    payload_all = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      payload_all[8*i +: 8] = cell_q[i];
    end
  end

  if (PAYLOAD_BYTES >= 7) begin : g_rreq
    assign rreq_all = (cell_q[4] == ffr_pkg::RESET_MARK) &&
                      (cell_q[5] == ffr_pkg::RESET_MARK) &&
                      (cell_q[6] == ffr_pkg::RESET_MARK);
  end else begin : g_no_rreq
    assign rreq_all = 1'b0;
  end

  assign done          = (ctl.status == ffr_pkg::ST_DONE);
  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= ctl.status;
      payload_r <= done ? payload_all : 64'd0;
      rreq_r    <= done && rreq_all;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_payload       = payload_r;
  assign out_reset_request = rreq_r;

`ifndef ASSERT_OFF
  a_rreq_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reset_request |-> out_status == ffr_pkg::ST_DONE)
    else $error("reset request without a complete frame");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffr_pkg::ST_DONE |-> out_payload == 64'd0)
    else $error("payload not zero on a non-complete status");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("transfer in produced no result");

  a_shift_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift |-> ctl.status == ffr_pkg::ST_ACCEPT)
    else $error("payload chain shifts on a non-accepted byte");
`endif

endmodule

`default_nettype wire

>>> tb/sv/fixed_frame_receiver_sum_check_tb.sv
// ----------------------------------------------------------------------------
// fixed_frame_receiver_sum_check_tb
// Streams received bytes into the frame receiver: a short directed table of
// header, hunting and complete-frame cases, then mostly well-formed frames
// with random content, broken headers, bad checksums, cut-off frames and
// noise. Runs over several register settings. Every result is checked
// against the directed table or the frame protocol decoder held in this bench.
// ----------------------------------------------------------------------------
module fixed_frame_receiver_sum_check_tb;

  localparam int PAYLOAD_BYTES = 8;
  localparam int CHECK_POS     = ffr_pkg::HEADER_LEN + PAYLOAD_BYTES;
  localparam int FRAME_LEN     = CHECK_POS + 1;
  localparam int PHASE_BYTES   = 190;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RUN_LIMIT     = 400000;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    ffr_pkg::status_t status;
    logic [63:0]      payload;
    logic             reset_request;
  } rx_result_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    rx_result_t res;
  } dir_row_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SOURCE,
    FRAME_BAD_DEST,
    FRAME_BAD_SUM,
    FRAME_SHORT
  } frame_flaw_t;

  localparam int DIRECTED_ROWS = 19;
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, '{ffr_pkg::ST_HUNT,    64'h0, 1'b0}},
    '{8'hAC, 1'b1, '{ffr_pkg::ST_ACCEPT,  64'h0, 1'b0}},
    '{8'hFF, 1'b1, '{ffr_pkg::ST_HDR_BAD, 64'h0, 1'b0}},
    '{8'hAC, 1'b1, '{ffr_pkg::ST_ACCEPT,  64'h0, 1'b0}},
    '{8'h02, 1'b1, '{ffr_pkg::ST_ACCEPT,  64'h0, 1'b0}},
    // wrong destination that happens to be the start byte: not taken again
    '{8'hAC, 1'b1, '{ffr_pkg::ST_HDR_BAD, 64'h0, 1'b0}},
    '{8'h02, 1'b1, '{ffr_pkg::ST_HUNT,    64'h0, 1'b0}},
    '{8'hAC, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h11, 1'b0, '0},
    '{8'h22, 1'b0, '0},
    '{8'hDD, 1'b0, '0},
    '{8'hDD, 1'b0, '0},
    '{8'hDD, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hF7, 1'b1, '{ffr_pkg::ST_DONE, 64'h80DD_DDDD_2211_00FF, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_payload;
  logic        out_reset_request;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // decoder state and its copy of the registers
  logic [7:0] cur_start;
  logic [7:0] cur_source;
  logic [7:0] cur_dest;
  logic [3:0] frame_pos;
  logic [7:0] frame_sum;
  logic [7:0] frame_store [8];

  rx_result_t rx_reports_due [$];
  int         mismatch_count = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;
  logic [9:0] stall_tick = '0;

  fixed_frame_receiver_sum_check #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_payload      (out_payload),
    .out_reset_request(out_reset_request),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic rx_result_t decode_rx_byte(input logic [7:0] b);
    rx_result_t r;
    logic [7:0] want;
    r = '0;
    if (frame_pos == 4'd0) begin
      if (b == cur_start) r.status = ffr_pkg::ST_ACCEPT;
    end else if (frame_pos <= 4'd2) begin
      want = (frame_pos == 4'd1) ? cur_source : cur_dest;
      r.status = (b == want) ? ffr_pkg::ST_ACCEPT : ffr_pkg::ST_HDR_BAD;
    end else if (frame_pos < CHECK_POS) begin
      frame_store[frame_pos - ffr_pkg::HEADER_LEN] = b;
      r.status = ffr_pkg::ST_ACCEPT;
    end else if (frame_pos == CHECK_POS) begin
      if (b == frame_sum) begin
        r.status = ffr_pkg::ST_DONE;
        for (int i = 0; i < PAYLOAD_BYTES; i++) r.payload[8*i +: 8] = frame_store[i];
        r.reset_request = (PAYLOAD_BYTES >= 7) &&
                          frame_store[4] == ffr_pkg::RESET_MARK &&
                          frame_store[5] == ffr_pkg::RESET_MARK &&
                          frame_store[6] == ffr_pkg::RESET_MARK;
      end else begin
        r.status = ffr_pkg::ST_SUM_BAD;
      end
    end
    // advance on a taken byte, otherwise drop back to hunting
    if (r.status == ffr_pkg::ST_ACCEPT) begin
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      frame_sum = '0;
      frame_pos = '0;
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input rx_result_t typed_res = '0);
    rx_result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = decode_rx_byte(b);
    rx_reports_due.push_back(typed ? typed_res : r);
    burst_left--;
    bytes_sent++;
  endtask

  // hold the sender until every outstanding result has been taken
  task automatic drain_reports();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (rx_reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (rx_reports_due.size() != 0) begin
      $error("%0d results never arrived", rx_reports_due.size());
      mismatch_count++;
    end
  endtask

  task automatic load_config(input logic [7:0] sb, input logic [7:0] si,
                             input logic [7:0] di, input logic poke_spare);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    int n;
    drain_reports();
    idx = '{ffr_pkg::CFG_START_BYTE, ffr_pkg::CFG_SOURCE_ID, ffr_pkg::CFG_DEST_ID,
            CFG_SPARE};
    val = '{sb, si, di, 8'($urandom)};
    n = poke_spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (idx[k])
        ffr_pkg::CFG_START_BYTE: cur_start  = val[k];
        ffr_pkg::CFG_SOURCE_ID:  cur_source = val[k];
        ffr_pkg::CFG_DEST_ID:    cur_dest   = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input frame_flaw_t flaw);
    logic [7:0] fr [FRAME_LEN];
    logic [7:0] sum;
    int marks;
    int len;
    fr[0] = cur_start;
    fr[1] = cur_source;
    fr[2] = cur_dest;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      case ($urandom_range(0, 7))
        0:       fr[ffr_pkg::HEADER_LEN + i] = 8'h00;
        1:       fr[ffr_pkg::HEADER_LEN + i] = 8'hFF;
        default: fr[ffr_pkg::HEADER_LEN + i] = 8'($urandom);
      endcase
    end
    // reset marker: all three bytes, or a near miss with one byte off
    marks = $urandom_range(0, 99);
    if (marks < 40 && PAYLOAD_BYTES >= 7) begin
      for (int i = 4; i <= 6; i++) fr[ffr_pkg::HEADER_LEN + i] = ffr_pkg::RESET_MARK;
      if (marks >= 25)
        fr[ffr_pkg::HEADER_LEN + $urandom_range(4, 6)] =
          ffr_pkg::RESET_MARK ^ 8'($urandom_range(1, 255));
    end
    sum = '0;
    for (int i = 0; i < CHECK_POS; i++) sum = sum + fr[i];
    fr[CHECK_POS] = sum;
    len = FRAME_LEN;
    case (flaw)
      FRAME_BAD_SOURCE: fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
      FRAME_BAD_DEST:   fr[2] = fr[2] ^ 8'($urandom_range(1, 255));
      FRAME_BAD_SUM:    fr[CHECK_POS] = fr[CHECK_POS] ^ 8'($urandom_range(1, 255));
      FRAME_SHORT:      len = $urandom_range(1, FRAME_LEN - 1);
      default: ;
    endcase
    for (int i = 0; i < len; i++) send_byte(fr[i]);
  endtask

  // receiver: cycle through free-running, mostly-ready, strided and coin-flip ready
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= (stall_tick[1:0] == 2'd0);
      default: out_ready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    rx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rx_reports_due.size() == 0) begin
        $error("result transfer with nothing outstanding, status %0d", out_status);
        mismatch_count++;
      end else begin
        want = rx_reports_due.pop_front();
        if (out_status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_payload !== want.payload) begin
          $error("payload expected %h got %h", want.payload, out_payload);
          mismatch_count++;
        end
        if (out_reset_request !== want.reset_request) begin
          $error("reset_request expected %0b got %0b", want.reset_request,
                 out_reset_request);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("fixed_frame_receiver_sum_check verification failed");
    $finish;
  end

  initial begin
    int pick;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cur_start  = ffr_pkg::START_BYTE_RST;
    cur_source = ffr_pkg::SOURCE_ID_RST;
    cur_dest   = ffr_pkg::DEST_ID_RST;
    frame_pos  = '0;
    frame_sum  = '0;
    for (int i = 0; i < 8; i++) frame_store[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIRECTED_ROWS; k++)
      send_byte(DIRECTED[k].rx, DIRECTED[k].typed, DIRECTED[k].res);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       load_config(8'h00, 8'h00, 8'h00, 1'b1);
        1:       load_config(8'hFF, 8'hFF, 8'hFF, 1'b0);
        3:       load_config(8'hFF, 8'h00, 8'hFF, 1'b1);
        5:       load_config(ffr_pkg::START_BYTE_RST, ffr_pkg::SOURCE_ID_RST,
                             ffr_pkg::DEST_ID_RST, 1'b0);
        default: load_config(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      endcase
      if (p == 0) send_frame(FRAME_BAD_SUM);
      while (bytes_sent < DIRECTED_ROWS + (p + 1) * PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      send_frame(FRAME_GOOD);
        else if (pick < 76) send_frame(FRAME_BAD_SOURCE);
        else if (pick < 82) send_frame(FRAME_BAD_DEST);
        else if (pick < 88) send_frame(FRAME_BAD_SUM);
        else if (pick < 94) send_frame(FRAME_SHORT);
        else repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end

    drain_reports();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("fixed_frame_receiver_sum_check verification clean");
    else
      $display("fixed_frame_receiver_sum_check verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/ffr_pkg.sv
rtl/ffr_cell.sv
rtl/ffr_ctrl.sv
rtl/fixed_frame_receiver_sum_check.sv
tb/sv/fixed_frame_receiver_sum_check_tb.sv
